// ===== hw/rtl/optgen_pkg.sv =====
// optgen_pkg: shared constants, widths and types for the reuse decision block
// used by optgen_engine and optgen_reuse_decision_top; depends on nothing

package optgen_pkg;

  // sizing of the tracked sets, history window and associativity
  localparam int SET_COUNT   = 64;
  localparam int HISTORY_MAX = 128;
  localparam int MAX_WAYS    = 16;

  // fixed field widths
  localparam int SET_IN_W  = 6;
  localparam int ADDR_IN_W = 64;
  localparam int WAYS_W    = 5;
  localparam int HIST_W    = 8;
  localparam int OCC_W     = 5;

  // derived widths
  localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int SLOT_W    = $clog2(HISTORY_MAX);
  localparam int LEN_W     = $clog2(HISTORY_MAX + 1);
  localparam int CNT_W     = $clog2(HISTORY_MAX + 2);
  localparam int MEM_AW    = SET_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam int SET_DEPTH = 1 << SET_W;

  // stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = ((SET_IN_W + ADDR_IN_W + 7) / 8) * 8;
  localparam int M_TDATA_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = HIST_W;
  localparam int WAYS_RST   = 16;
  localparam int HIST_RST   = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAYS    = 1'b0,
    REG_HISTORY = 1'b1
  } cfg_reg_e;

  typedef logic [SET_W-1:0]     set_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [SLOT_W:0]      slot_ext_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [MEM_AW-1:0]    maddr_t;
  typedef logic [WAYS_W-1:0]    ways_t;
  typedef logic [OCC_W-1:0]     occ_t;
  typedef logic [ADDR_IN_W-1:0] line_t;

  // effective settings seen by the engine
  typedef struct packed {
    len_t  len;
    ways_t ways;
  } cfg_t;

endpackage

// ===== hw/rtl/optgen_engine.sv =====
// optgen_engine: per-set occupancy and address history kept in synchronous memories
// depends on optgen_pkg; sequences one request at a time through read-modify-write steps

module optgen_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  optgen_pkg::cfg_t                    cfg_i,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  logic [optgen_pkg::SET_IN_W-1:0]     req_set_i,
  input  logic [optgen_pkg::ADDR_IN_W-1:0]    req_addr_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic                                res_friendly_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POS_RD,
    ST_POS_UPD,
    ST_SEARCH,
    ST_INC,
    ST_WRITE,
    ST_DONE
  } state_e;

  // step one slot back around the window
  function automatic optgen_pkg::slot_t slot_dec(optgen_pkg::slot_t s, optgen_pkg::len_t len);
    slot_dec = (s == '0) ? optgen_pkg::slot_t'(len - optgen_pkg::len_t'(1))
                         : s - optgen_pkg::slot_t'(1);
  endfunction

  state_e                 state_q, state_d;
  optgen_pkg::set_t       set_q, set_d;
  optgen_pkg::line_t      addr_q, addr_d;
  optgen_pkg::slot_t      pos_q, pos_d;
  optgen_pkg::slot_t      slot_q, slot_d;
  optgen_pkg::slot_t      wslot_q, wslot_d;
  optgen_pkg::cnt_t       cnt_q, cnt_d;
  optgen_pkg::len_t       hit_q, hit_d;
  logic                   pend_q, pend_d;
  logic                   full_q, full_d;
  logic                   friendly_q, friendly_d;
  optgen_pkg::maddr_t     clr_q, clr_d;

  // memories
  optgen_pkg::occ_t                      occ_mem [optgen_pkg::MEM_DEPTH];
  logic [optgen_pkg::ADDR_IN_W:0]        am_mem  [optgen_pkg::MEM_DEPTH];
  optgen_pkg::slot_t                     pos_mem [optgen_pkg::SET_DEPTH];

  logic                                  occ_we;
  optgen_pkg::maddr_t                    occ_waddr, occ_raddr;
  optgen_pkg::occ_t                      occ_wdata, occ_rdata_q;
  logic                                  am_we;
  optgen_pkg::maddr_t                    am_waddr, am_raddr;
  logic [optgen_pkg::ADDR_IN_W:0]        am_wdata, am_rdata_q;
  logic                                  pos_we;
  optgen_pkg::set_t                      pos_waddr;
  optgen_pkg::slot_t                     pos_wdata, pos_rdata_q;

  optgen_pkg::slot_ext_t                 pos_inc;
  optgen_pkg::slot_t                     pos_new;
  logic                                  addr_match;
  logic                                  occ_full;
  logic                                  full_now;

  // occupancy memory
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    occ_rdata_q <= occ_mem[occ_raddr];
  end

  // address history memory, valid mark in the top bit
  always_ff @(posedge clk_i) begin
    if (am_we) begin
      am_mem[am_waddr] <= am_wdata;
    end
    am_rdata_q <= am_mem[am_raddr];
  end

  // ring position memory
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata_q <= pos_mem[set_q];
  end

  // advanced ring position, wrapped at the window
  assign pos_inc = optgen_pkg::slot_ext_t'(pos_rdata_q) + optgen_pkg::slot_ext_t'(1);
  assign pos_new = (32'(pos_inc) >= 32'(cfg_i.len)) ? '0 : optgen_pkg::slot_t'(pos_inc);

  // compare of the pending history read
  assign addr_match = pend_q && am_rdata_q[optgen_pkg::ADDR_IN_W] &&
                      (am_rdata_q[optgen_pkg::ADDR_IN_W-1:0] == addr_q);
  assign occ_full   = (occ_rdata_q >= cfg_i.ways);
  assign full_now   = full_q | (pend_q & occ_full);

  // sequencer next state and memory control
  always_comb begin
    state_d    = state_q;
    set_d      = set_q;
    addr_d     = addr_q;
    pos_d      = pos_q;
    slot_d     = slot_q;
    wslot_d    = wslot_q;
    cnt_d      = cnt_q;
    hit_d      = hit_q;
    pend_d     = pend_q;
    full_d     = full_q;
    friendly_d = friendly_q;
    clr_d      = clr_q;

    occ_we     = 1'b0;
    occ_waddr  = {set_q, wslot_q};
    occ_wdata  = occ_rdata_q + optgen_pkg::occ_t'(1);
    occ_raddr  = {set_q, slot_q};
    am_we      = 1'b0;
    am_waddr   = {set_q, pos_q};
    am_wdata   = {1'b1, addr_q};
    am_raddr   = {set_q, slot_q};
    pos_we     = 1'b0;
    pos_waddr  = set_q;
    pos_wdata  = pos_new;

    case (state_q)
      // sweep every entry after reset
      ST_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = '0;
        am_we     = 1'b1;
        am_waddr  = clr_q;
        am_wdata  = '0;
        pos_we    = 1'b1;
        pos_waddr = clr_q[optgen_pkg::MEM_AW-1 -: optgen_pkg::SET_W];
        pos_wdata = '0;
        clr_d     = clr_q + optgen_pkg::maddr_t'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      // take a request
      ST_IDLE: begin
        if (req_valid_i) begin
          set_d      = optgen_pkg::set_t'(req_set_i);
          addr_d     = req_addr_i;
          friendly_d = 1'b0;
          if (32'(req_set_i) >= optgen_pkg::SET_COUNT) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_POS_RD;
          end
        end
      end
      // position read in flight
      ST_POS_RD: begin
        state_d = ST_POS_UPD;
      end
      // advance position and zero the newest occupancy slot
      ST_POS_UPD: begin
        pos_we    = 1'b1;
        occ_we    = 1'b1;
        occ_waddr = {set_q, pos_new};
        occ_wdata = '0;
        pos_d     = pos_new;
        slot_d    = slot_dec(pos_new, cfg_i.len);
        cnt_d     = optgen_pkg::cnt_t'(1);
        pend_d    = 1'b0;
        full_d    = 1'b0;
        state_d   = ST_SEARCH;
      end
      // backward search, occupancy checked along the way
      ST_SEARCH: begin
        if (addr_match) begin
          hit_d      = optgen_pkg::len_t'(cnt_q - optgen_pkg::cnt_t'(1));
          friendly_d = !full_now;
          slot_d     = slot_dec(pos_q, cfg_i.len);
          cnt_d      = optgen_pkg::cnt_t'(1);
          pend_d     = 1'b0;
          state_d    = full_now ? ST_WRITE : ST_INC;
        end else if (32'(cnt_q) > 32'(cfg_i.len)) begin
          friendly_d = 1'b0;
          pend_d     = 1'b0;
          state_d    = ST_WRITE;
        end else begin
          pend_d = 1'b1;
          full_d = full_now;
          cnt_d  = cnt_q + optgen_pkg::cnt_t'(1);
          slot_d = slot_dec(slot_q, cfg_i.len);
        end
      end
      // increment walk over the reuse interval
      ST_INC: begin
        occ_we = pend_q;
        if (32'(cnt_q) <= 32'(hit_q)) begin
          wslot_d = slot_q;
          slot_d  = slot_dec(slot_q, cfg_i.len);
          cnt_d   = cnt_q + optgen_pkg::cnt_t'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_WRITE;
          end
        end
      end
      // record the access in the history
      ST_WRITE: begin
        am_we   = 1'b1;
        state_d = ST_DONE;
      end
      // hand over the decision
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      set_q      <= '0;
      addr_q     <= '0;
      pos_q      <= '0;
      slot_q     <= '0;
      wslot_q    <= '0;
      cnt_q      <= '0;
      hit_q      <= '0;
      pend_q     <= 1'b0;
      full_q     <= 1'b0;
      friendly_q <= 1'b0;
      clr_q      <= '0;
    end else begin
      state_q    <= state_d;
      set_q      <= set_d;
      addr_q     <= addr_d;
      pos_q      <= pos_d;
      slot_q     <= slot_d;
      wslot_q    <= wslot_d;
      cnt_q      <= cnt_d;
      hit_q      <= hit_d;
      pend_q     <= pend_d;
      full_q     <= full_d;
      friendly_q <= friendly_d;
      clr_q      <= clr_d;
    end
  end

  assign req_ready_o    = (state_q == ST_IDLE);
  assign res_valid_o    = (state_q == ST_DONE);
  assign res_friendly_o = friendly_q;

  // walk pointer stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH || state_q == ST_INC) |-> (32'(slot_q) < 32'(cfg_i.len)))
    else $error("history slot outside window");

  // stored ring position stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POS_UPD) |=> (32'(pos_q) < 32'(cfg_i.len)))
    else $error("ring position outside window");

  // increment walk only follows a found, unblocked reuse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INC) |-> (friendly_q && hit_q != '0))
    else $error("increment without friendly reuse");

  // every incremented slot was below the way count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INC && pend_q) |-> (occ_rdata_q < cfg_i.ways))
    else $error("increment of a full occupancy slot");

endmodule

// ===== hw/rtl/optgen_reuse_decision_top.sv =====
// Reuse decision block, top level: stream handshakes, configuration registers
// and the output register. Depends on optgen_pkg and optgen_engine.
//
// Usage: each request on the slave stream is one access to a sampled set
// (set index and line address). For each request exactly one decision
// comes out on the master stream: 1 when the reuse would have hit under
// the optimal policy, 0 otherwise.
// Flow: one request at a time. The time that a request takes is set by the
// backward walk over the address history memory, one slot a cycle, and,
// when its reuse is friendly, by the increment walk over the occupancy
// memory.
// Reset: a clearing pass sweeps all 8192 history and occupancy entries,
// one a cycle; no request is taken until the pass is over, but the
// configuration port writes at any time.
// Stall: a decision waits in the output register; the engine holds its
// next decision until that register frees, and s_axis_tready stays low
// while a request is in work.

module optgen_reuse_decision_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [optgen_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [optgen_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // request stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [optgen_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // set_index, line_address
  // decision stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [optgen_pkg::M_TDATA_W-1:0]     m_axis_tdata    // cache_friendly
);

  optgen_pkg::ways_t                    ways_q;
  logic [optgen_pkg::HIST_W-1:0]        hist_q;
  optgen_pkg::cfg_t                     cfg;
  logic                                 res_valid;
  logic                                 res_ready;
  logic                                 res_friendly;
  logic                                 out_valid_q;
  logic                                 out_friendly_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= optgen_pkg::ways_t'(optgen_pkg::WAYS_RST);
      hist_q <= optgen_pkg::HIST_W'(optgen_pkg::HIST_RST);
    end else if (cfg_we_i) begin
      case (optgen_pkg::cfg_reg_e'(cfg_addr_i))
        optgen_pkg::REG_WAYS: begin
          ways_q <= cfg_wdata_i[optgen_pkg::WAYS_W-1:0];
        end
        optgen_pkg::REG_HISTORY: begin
          hist_q <= cfg_wdata_i[optgen_pkg::HIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective window and way limit
  always_comb begin
    if (hist_q == '0) begin
      cfg.len = optgen_pkg::len_t'(1);
    end else if (32'(hist_q) > optgen_pkg::HISTORY_MAX) begin
      cfg.len = optgen_pkg::len_t'(optgen_pkg::HISTORY_MAX);
    end else begin
      cfg.len = optgen_pkg::len_t'(hist_q);
    end
    if (32'(ways_q) > optgen_pkg::MAX_WAYS) begin
      cfg.ways = optgen_pkg::ways_t'(optgen_pkg::MAX_WAYS);
    end else begin
      cfg.ways = ways_q;
    end
  end

  optgen_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_set_i      (s_axis_tdata[optgen_pkg::SET_IN_W-1:0]),
    .req_addr_i     (s_axis_tdata[optgen_pkg::SET_IN_W +: optgen_pkg::ADDR_IN_W]),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_friendly_o (res_friendly)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      out_friendly_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q    <= res_valid;
      out_friendly_q <= res_friendly;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(optgen_pkg::M_TDATA_W-1){1'b0}}, out_friendly_q};

endmodule
